FILE: hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sse_pkg.sv
package sse_pkg;

    localparam int MUL_W  = 35;
    localparam int PROD_W = 2 * MUL_W;

    localparam int NUM_PARTIALS = 4;
    localparam int STAGE_W      = 3;
    localparam int PH_W         = 32;
    localparam int INC_W        = 40;
    localparam int QUOT_W       = 23;
    localparam int SAMPLE_W     = 24;

    localparam logic [STAGE_W-1:0] STAGE_FADE_IN  = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_FADE_OUT = 3'd6;
    localparam logic [STAGE_W-1:0] STAGE_SILENT   = 3'd7;

    localparam logic [31:0] FIT_A     = 32'd2821167616;
    localparam logic [31:0] FIT_B     = 32'd1473799808;
    localparam logic [16:0] SAW_LEVEL = 17'd91750;
    localparam logic [14:0] TAP_GAIN  = 15'd19661;
    localparam logic [12:0] OUT_GAIN  = 13'd6554;
    localparam int          SNAP_LSB  = 21;

    localparam logic [2:0] REG_GAIN_TARGET   = 3'd0;
    localparam logic [2:0] REG_ECHO_SEND     = 3'd1;
    localparam logic [2:0] REG_ECHO_FEEDBACK = 3'd2;
    localparam logic [2:0] REG_GLIDE_STEP    = 3'd3;
    localparam logic [2:0] REG_VIB_DEPTH     = 3'd4;
    localparam logic [2:0] REG_VIB_STEP      = 3'd5;
    localparam logic [2:0] REG_BASE_INC      = 3'd6;
    localparam logic [2:0] REG_RAMP_COEFF    = 3'd7;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [28:0] x);
        logic signed [28:0] hi;
        logic signed [28:0] lo;
        hi = 29'sd8388607;
        lo = -29'sd8388608;
        if (x > hi) begin
            return 24'sh7fffff;
        end else if (x < lo) begin
            return 24'sh800000;
        end
        return x[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/sse_mul.sv
module sse_mul
    import sse_pkg::*;
(
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

FILE: hw/rtl/sse_div.sv
module sse_div
    import sse_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PH_W-1:0]   i_num,
    input  logic [INC_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    // restoring division, one quotient bit per cycle; numerator is below the divisor
    logic [INC_W-1:0]  r_rem;
    logic [INC_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_quot;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [INC_W:0]    rem2;
    logic              ge;
    logic [INC_W:0]    n_rem;

    always_comb begin
        rem2  = {r_rem, 1'b0};
        ge    = rem2 >= {1'b0, r_den};
        n_rem = ge ? rem2 - {1'b0, r_den} : rem2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(QUOT_W);
                r_rem  <= INC_W'(i_num);
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem[INC_W-1:0];
                r_quot <= {r_quot[QUOT_W-2:0], ge};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: hw/rtl/shepard_saw_echo_generator.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: in_left[23:0], in_right[47:24]
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: out_left[23:0], out_right[47:24]
// cfg       in   i_cfg_we                       i_cfg_idx register index, i_cfg_data value
//
// a frame runs 8 setup steps, 5 steps per sounding partial and 9 steps to finish and push;
// a silent partial takes 1 step instead of 5, and each partial whose saw wraps adds a wait
// on the iterative divider (one quotient bit per cycle).
// all products go through one shared registered multiplier.
// after reset the echo lines are cleared at one entry a cycle until the longer line is swept,
// with s_axis_tready low; config writes are taken meanwhile.
// a finished frame waits in the output register; the next frame is accepted meanwhile
// and stalls only at its last step if the earlier result is still not taken.
module shepard_saw_echo_generator
    import sse_pkg::*;
#(
    parameter int ECHO_A_LEN = 4096,
    parameter int ECHO_B_LEN = 512
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // in_left, in_right
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // out_left, out_right
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

`include "assert_macros.svh"

    localparam int AW_A    = $clog2(ECHO_A_LEN);
    localparam int AW_B    = $clog2(ECHO_B_LEN);
    localparam int MAX_LEN = (ECHO_A_LEN > ECHO_B_LEN) ? ECHO_A_LEN : ECHO_B_LEN;
    localparam int CLR_W   = $clog2(MAX_LEN);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_GAIN1, S_GAIN2, S_VIB, S_PP, S_FA, S_FB, S_T1, S_IB,
        S_PART, S_W2, S_DIV, S_VW, S_LVL, S_ACC, S_GLIDE, S_TG, S_WS, S_WF,
        S_TA, S_OL, S_TB, S_OR, S_PUSH
    } t_state;

    t_state r_state;

    // configuration
    logic [15:0] r_gt, r_send, r_fb, r_ramp;
    logic [31:0] r_gs, r_vs, r_base;
    logic [14:0] r_vd;

    // tone state
    logic [31:0]        r_glide;
    logic [30:0]        r_vib_phase;
    logic [15:0]        r_gain;
    logic [PH_W-1:0]    r_saw   [NUM_PARTIALS];
    logic [STAGE_W-1:0] r_stage [NUM_PARTIALS];

    // echo lines
    logic signed [SAMPLE_W-1:0] r_mem_a [ECHO_A_LEN];
    logic signed [SAMPLE_W-1:0] r_mem_b [ECHO_B_LEN];
    logic signed [SAMPLE_W-1:0] r_rd_a, r_rd_b;
    logic signed [SAMPLE_W-1:0] r_tap_b;
    logic [AW_A-1:0]            r_ptr_a;
    logic [AW_B-1:0]            r_ptr_b;
    logic [CLR_W-1:0]           r_clr_cnt;

    // per-frame work registers
    logic signed [SAMPLE_W-1:0] r_in_l, r_in_r;
    logic [31:0]                r_vib, r_pp;
    logic [33:0]                r_poly, r_inc_base;
    logic [32:0]                r_q;
    logic [1:0]                 r_k;
    logic signed [25:0]         r_tone, r_t;
    logic [INC_W-1:0]           r_inc;
    logic [PH_W-1:0]            r_ph;
    logic                       r_wrap;
    logic [32:0]                r_w2;
    logic signed [SAMPLE_W-1:0] r_v;
    logic signed [27:0]         r_wa;
    logic signed [SAMPLE_W-1:0] r_res_l, r_res_r, r_out_l, r_out_r;
    logic                       r_out_valid;

    // shared units
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start, div_done;
    logic [QUOT_W-1:0]        div_quot;

    sse_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    sse_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_ph),
        .i_den   (r_inc),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // combinational helpers
    logic signed [16:0]  diff;
    logic [15:0]         gn1;
    logic signed [16:0]  diff2;
    logic [31:0]         tri_v;
    logic signed [31:0]  tri_m;
    logic [STAGE_W-1:0]  s_k;
    logic [INC_W-1:0]    inc_k;
    logic [INC_W:0]      sum_k;
    logic [16:0]         w16;
    logic signed [33:0]  step34, np;
    logic                glide_wrap;
    logic signed [26:0]  tap_x;
    logic signed [28:0]  wa_sum;
    logic                push_ok;
    logic                last_k;

    always_comb begin
        diff   = signed'({1'b0, r_gt}) - signed'({1'b0, r_gain});
        gn1    = 16'({2'b00, r_gain} + prod[33:16]);
        diff2  = signed'({1'b0, r_gt}) - signed'({1'b0, gn1});
        tri_v  = r_vib_phase[30] ? 32'h8000_0000 - {1'b0, r_vib_phase} : {1'b0, r_vib_phase};
        tri_m  = signed'(tri_v) - 32'sh2000_0000;
        s_k    = r_stage[r_k];
        inc_k  = INC_W'(r_inc_base) << s_k;
        sum_k  = (INC_W+1)'(r_saw[r_k]) + {1'b0, inc_k};
        if (s_k == STAGE_FADE_IN) begin
            w16 = r_q[32:16];
        end else if (s_k == STAGE_FADE_OUT) begin
            w16 = 17'((33'h1_0000_0000 - r_q) >> 16);
        end else begin
            w16 = 17'h10000;
        end
        step34     = {r_gs[31], r_gs, 1'b0};
        np         = signed'({2'b00, r_glide}) + step34;
        glide_wrap = (!r_gs[31] && (r_gs != 32'd0) && np[32]) || (r_gs[31] && np[33]);
        tap_x      = 27'(r_t) + 27'(signed'(prod[38:16]));
        wa_sum     = 29'(r_wa) + 29'(signed'(prod[39:16]));
        push_ok    = !r_out_valid || m_axis_tready;
        last_k     = r_k == 2'(NUM_PARTIALS - 1);
    end

    // multiplier operand select and divider start
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_GAIN1: begin
                mul_a = MUL_W'(diff);
                mul_b = MUL_W'(r_ramp);
            end
            S_GAIN2: begin
                mul_a = MUL_W'(tri_m);
                mul_b = MUL_W'(r_vd);
            end
            S_VIB: begin
                mul_a = MUL_W'(r_glide);
                mul_b = MUL_W'(r_glide);
            end
            S_PP: begin
                mul_a = MUL_W'(FIT_A);
                mul_b = MUL_W'(r_glide);
            end
            S_FA: begin
                mul_a = MUL_W'(FIT_B);
                mul_b = MUL_W'(r_pp);
            end
            S_FB: begin
                mul_a = MUL_W'(r_base);
                mul_b = MUL_W'(r_vib);
            end
            S_T1: begin
                mul_a = MUL_W'(prod[63:30]);
                mul_b = MUL_W'(r_poly[33:2]);
            end
            S_PART: begin
                mul_a = MUL_W'(w16);
                mul_b = MUL_W'(w16);
            end
            S_W2: begin
                div_start = r_wrap;
            end
            S_VW: begin
                mul_a = MUL_W'(r_v);
                mul_b = MUL_W'(r_w2);
            end
            S_LVL: begin
                mul_a = MUL_W'(signed'(prod[55:32]));
                mul_b = MUL_W'(SAW_LEVEL);
            end
            S_GLIDE: begin
                mul_a = MUL_W'(r_tone);
                mul_b = MUL_W'(r_gain);
            end
            S_TG: begin
                mul_a = MUL_W'(signed'(prod[41:16]));
                mul_b = MUL_W'(r_send);
            end
            S_WS: begin
                mul_a = MUL_W'(r_rd_b);
                mul_b = MUL_W'(r_fb);
            end
            S_WF: begin
                mul_a = MUL_W'(r_rd_a);
                mul_b = MUL_W'(TAP_GAIN);
            end
            S_TA, S_TB: begin
                mul_a = MUL_W'(tap_x);
                mul_b = MUL_W'(OUT_GAIN);
            end
            S_OL: begin
                mul_a = MUL_W'(r_tap_b);
                mul_b = MUL_W'(TAP_GAIN);
            end
            default: begin
            end
        endcase
    end

    // echo memories: clear sweep, or one write per frame
    logic                       we_a, we_b;
    logic [AW_A-1:0]            wad_a;
    logic [AW_B-1:0]            wad_b;
    logic signed [SAMPLE_W-1:0] wd_a, wd_b;

    always_comb begin
        if (r_state == S_CLEAR) begin
            we_a  = {1'b0, r_clr_cnt} < (CLR_W+1)'(ECHO_A_LEN);
            we_b  = {1'b0, r_clr_cnt} < (CLR_W+1)'(ECHO_B_LEN);
            wad_a = AW_A'(r_clr_cnt);
            wad_b = AW_B'(r_clr_cnt);
            wd_a  = '0;
            wd_b  = '0;
        end else begin
            we_a  = r_state == S_WF;
            we_b  = r_state == S_WF;
            wad_a = r_ptr_a;
            wad_b = r_ptr_b;
            wd_a  = sat24(wa_sum);
            wd_b  = r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_mem_a[wad_a] <= wd_a;
        end
        r_rd_a <= r_mem_a[r_ptr_a];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_mem_b[wad_b] <= wd_b;
        end
        r_rd_b <= r_mem_b[r_ptr_b];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_gt        <= '0;
            r_send      <= '0;
            r_fb        <= '0;
            r_gs        <= '0;
            r_vd        <= '0;
            r_vs        <= '0;
            r_base      <= '0;
            r_ramp      <= '0;
            r_glide     <= '0;
            r_vib_phase <= '0;
            r_gain      <= '0;
            r_ptr_a     <= '0;
            r_ptr_b     <= '0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            for (int i = 0; i < NUM_PARTIALS; i++) begin
                r_saw[i]   <= '0;
                r_stage[i] <= STAGE_W'(2 * i);
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_GAIN_TARGET:   r_gt   <= i_cfg_data[15:0];
                    REG_ECHO_SEND:     r_send <= i_cfg_data[15:0];
                    REG_ECHO_FEEDBACK: r_fb   <= i_cfg_data[15:0];
                    REG_GLIDE_STEP:    r_gs   <= i_cfg_data;
                    REG_VIB_DEPTH:     r_vd   <= i_cfg_data[14:0];
                    REG_VIB_STEP:      r_vs   <= i_cfg_data;
                    REG_BASE_INC:      r_base <= i_cfg_data;
                    REG_RAMP_COEFF:    r_ramp <= i_cfg_data[15:0];
                endcase
            end

            if (r_state == S_PUSH && push_ok) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (r_clr_cnt == CLR_W'(MAX_LEN - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in_l  <= s_axis_tdata[23:0];
                        r_in_r  <= s_axis_tdata[47:24];
                        r_state <= S_GAIN1;
                    end
                end
                S_GAIN1: begin
                    if (r_vd != '0) begin
                        r_vib_phase <= 31'({1'b0, r_vib_phase} + r_vs);
                    end
                    r_state <= S_GAIN2;
                end
                S_GAIN2: begin
                    // ramp, then snap when within tolerance
                    if (diff2 > -17'(SNAP_LSB) && diff2 < 17'(SNAP_LSB)) begin
                        r_gain <= r_gt;
                    end else begin
                        r_gain <= gn1;
                    end
                    r_state <= S_VIB;
                end
                S_VIB: begin
                    r_vib   <= (r_vd != '0) ? 32'h4000_0000 + prod[47:16] : 32'h4000_0000;
                    r_state <= S_PP;
                end
                S_PP: begin
                    r_pp    <= prod[63:32];
                    r_state <= S_FA;
                end
                S_FA: begin
                    r_poly  <= 34'h1_0000_0000 + 34'(prod[63:32]);
                    r_state <= S_FB;
                end
                S_FB: begin
                    r_poly  <= r_poly + 34'(prod[63:32]);
                    r_state <= S_T1;
                end
                S_T1: begin
                    r_state <= S_IB;
                end
                S_IB: begin
                    r_inc_base <= prod[63:30];
                    r_q        <= r_gs[31] ? 33'h1_0000_0000 - {1'b0, r_glide}
                                           : {1'b0, r_glide};
                    r_k        <= '0;
                    r_tone     <= '0;
                    r_state    <= S_PART;
                end
                S_PART: begin
                    if (s_k == STAGE_SILENT) begin
                        r_k     <= r_k + 2'd1;
                        r_state <= last_k ? S_GLIDE : S_PART;
                    end else begin
                        r_inc      <= inc_k;
                        r_ph       <= sum_k[PH_W-1:0];
                        r_wrap     <= (sum_k[INC_W:PH_W] != '0) && (inc_k != '0);
                        r_saw[r_k] <= sum_k[PH_W-1:0];
                        r_state    <= S_W2;
                    end
                end
                S_W2: begin
                    r_w2 <= prod[32:0];
                    if (r_wrap) begin
                        r_state <= S_DIV;
                    end else begin
                        r_v     <= 24'sh400000 - 24'(r_ph >> 9);
                        r_state <= S_VW;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_v     <= signed'({1'b0, div_quot}) - 24'sh400000;
                        r_state <= S_VW;
                    end
                end
                S_VW: begin
                    r_state <= S_LVL;
                end
                S_LVL: begin
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_tone  <= r_tone + 26'(signed'(prod[40:16]));
                    r_k     <= r_k + 2'd1;
                    r_state <= last_k ? S_GLIDE : S_PART;
                end
                S_GLIDE: begin
                    r_glide <= np[31:0];
                    if (glide_wrap) begin
                        for (int i = 0; i < NUM_PARTIALS; i++) begin
                            r_stage[i] <= r_stage[i] + (r_gs[31] ? 3'd7 : 3'd1);
                        end
                    end
                    r_state <= S_TG;
                end
                S_TG: begin
                    r_t     <= signed'(prod[41:16]);
                    r_state <= S_WS;
                end
                S_WS: begin
                    // keep tap b, the read port moves on once the pointers advance
                    r_tap_b <= r_rd_b;
                    r_wa    <= signed'(prod[41:14]);
                    r_state <= S_WF;
                end
                S_WF: begin
                    r_ptr_a <= (r_ptr_a == AW_A'(ECHO_A_LEN - 1)) ? '0 : r_ptr_a + 1'b1;
                    r_ptr_b <= (r_ptr_b == AW_B'(ECHO_B_LEN - 1)) ? '0 : r_ptr_b + 1'b1;
                    r_state <= S_TA;
                end
                S_TA: begin
                    r_state <= S_OL;
                end
                S_OL: begin
                    r_res_l <= sat24(29'(r_in_l) + 29'(signed'(prod[39:16])));
                    r_state <= S_TB;
                end
                S_TB: begin
                    r_state <= S_OR;
                end
                S_OR: begin
                    r_res_r <= sat24(29'(r_in_r) + 29'(signed'(prod[39:16])));
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (push_ok) begin
                        r_out_l <= r_res_l;
                        r_out_r <= r_res_r;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_r, r_out_l};

    `ASSERT_IMPLY(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !s_axis_tready, "ready in clear")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready again")
    `ASSERT_NEXT(a_push_shows_result, i_clk, i_rst_n, r_state == S_PUSH && push_ok, m_axis_tvalid, "no result")

endmodule
